[rtl/md5_pkg.sv]
package md5_pkg;

  // Initial chaining words A..D
  localparam logic [31:0] MD5_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Per-round additive constants
  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed {quarter, round[1:0]}
  localparam logic [4:0] MD5_ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam logic [5:0] LEN_BYTE_POS = 6'd56;  // length field starts here
  localparam logic [3:0] LEN_LO_WORD  = 4'd14;
  localparam logic [3:0] LEN_HI_WORD  = 4'd15;
  localparam logic [3:0] LAST_WORD    = 4'd15;
  localparam logic [5:0] LAST_BYTE    = 6'd63;
  localparam logic [6:0] RND_DONE     = 7'd64;  // counter value during the last round
  localparam logic [1:0] LAST_DIGEST  = 2'd3;

  typedef struct packed {
    logic       push_byte;  // store in_tdata at current position
    logic       pad_wr;     // write the word holding the 0x80 marker
    logic       fill_wr;    // write zero or length word at word_addr
    logic       fill_len;   // this block carries the length field
    logic [3:0] word_addr;
    logic [5:0] rd_idx;     // round whose message word is fetched
    logic       rnd_load;   // copy chaining words into working regs
    logic       rnd_step;   // run one round
    logic [5:0] rnd_idx;
    logic       chain_add;
    logic       chain_init;
    logic [1:0] out_sel;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] pos;        // byte position within current block
  } md5_stat_t;

  // Message word index used by round i
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
      2'd3: g = 4'(i[3:0] * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] y;
    y = {32'h0, x} << s;
    return y[63:32] | y[31:0];
  endfunction

endpackage

[rtl/md5_ram.sv]
module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/md5_ctrl.sv]
module md5_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [1:0]        out_tuser,
  output logic              out_tlast,
  input  md5_pkg::md5_stat_t stat,
  output md5_pkg::md5_cmd_t  cmd
);
  import md5_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [6:0] rc_r, rc_nxt;
  logic [3:0] wc_r, wc_nxt;
  logic [1:0] oi_r, oi_nxt;
  logic       end_pend_r, end_pend_nxt;
  logic       padding_r, padding_nxt;
  logic       len_blk_r, len_blk_nxt;
  logic       in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = oi_r;
  assign out_tlast  = (oi_r == LAST_DIGEST);
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    rc_nxt       = rc_r;
    wc_nxt       = wc_r;
    oi_nxt       = oi_r;
    end_pend_nxt = end_pend_r;
    padding_nxt  = padding_r;
    len_blk_nxt  = len_blk_r;
    cmd          = '0;
    cmd.word_addr = wc_r;
    cmd.fill_len  = len_blk_r;
    cmd.rd_idx    = rc_r[5:0];
    cmd.rnd_idx   = 6'(rc_r - 7'd1);
    cmd.out_sel   = oi_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.push_byte = in_tuser;
          end_pend_nxt  = in_tlast;
          if (in_tuser && stat.pos == LAST_BYTE) begin
            rc_nxt    = '0;
            state_nxt = S_RND;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.pad_wr  = 1'b1;
        padding_nxt = 1'b1;
        len_blk_nxt = (stat.pos < LEN_BYTE_POS);
        if (stat.pos[5:2] == LAST_WORD) begin
          rc_nxt    = '0;
          state_nxt = S_RND;
        end else begin
          wc_nxt    = stat.pos[5:2] + 4'd1;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (wc_r == LAST_WORD) begin
          rc_nxt    = '0;
          state_nxt = S_RND;
        end else begin
          wc_nxt = wc_r + 4'd1;
        end
      end
      S_RND: begin
        cmd.rnd_load = (rc_r == '0);
        cmd.rnd_step = (rc_r != '0);
        if (rc_r == RND_DONE) begin
          state_nxt = S_ADD;
        end else begin
          rc_nxt = rc_r + 7'd1;
        end
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        priority if (!end_pend_r) begin
          state_nxt = S_IDLE;
        end else if (!padding_r) begin
          state_nxt = S_PAD;
        end else if (!len_blk_r) begin
          // marker landed in the length field: one more block of zeros + length
          len_blk_nxt = 1'b1;
          wc_nxt      = '0;
          state_nxt   = S_FILL;
        end else begin
          oi_nxt    = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (oi_r == LAST_DIGEST) begin
            cmd.chain_init = 1'b1;
            end_pend_nxt   = 1'b0;
            padding_nxt    = 1'b0;
            len_blk_nxt    = 1'b0;
            state_nxt      = S_IDLE;
          end else begin
            oi_nxt = oi_r + 2'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rc_r       <= '0;
      wc_r       <= '0;
      oi_r       <= '0;
      end_pend_r <= 1'b0;
      padding_r  <= 1'b0;
      len_blk_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rc_r       <= rc_nxt;
      wc_r       <= wc_nxt;
      oi_r       <= oi_nxt;
      end_pend_r <= end_pend_nxt;
      padding_r  <= padding_nxt;
      len_blk_r  <= len_blk_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output handshakes open together");

  a_rnd_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND && rc_r == RND_DONE) |=> (state_r == S_ADD))
    else $error("round sequence did not finish into chain add");

  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser && stat.pos == LAST_BYTE) |=> (state_r == S_RND && rc_r == '0))
    else $error("full block did not start compression");

  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (state_r == S_IDLE && !end_pend_r))
    else $error("digest end did not return to idle");

endmodule

[rtl/md5_dp.sv]
module md5_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  md5_pkg::md5_cmd_t  cmd,
  output md5_pkg::md5_stat_t stat,
  input  logic [7:0]         in_tdata,
  output logic [31:0]        out_tdata
);
  import md5_pkg::*;

  logic [31:0] cv_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [63:0] bit_cnt_r;
  logic [23:0] acc_r, acc_nxt;   // lower three bytes of the word being built

  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;
  logic [1:0]  lane;
  logic [3:0]  wptr;

  logic [1:0]  q;
  logic [31:0] f, sum, rot;

  assign lane = bit_cnt_r[4:3];
  assign wptr = bit_cnt_r[8:5];
  assign stat.pos = bit_cnt_r[8:3];
  assign out_tdata = cv_r[cmd.out_sel];

  // block buffer write side
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmd.word_addr;
    ram_wdata = '0;
    acc_nxt   = acc_r;
    if (cmd.push_byte) begin
      unique case (lane)
        2'd0: acc_nxt[7:0]   = in_tdata;
        2'd1: acc_nxt[15:8]  = in_tdata;
        2'd2: acc_nxt[23:16] = in_tdata;
        2'd3: begin
          ram_we    = 1'b1;
          ram_waddr = wptr;
          ram_wdata = {in_tdata, acc_r};
        end
      endcase
    end else if (cmd.pad_wr) begin
      ram_we    = 1'b1;
      ram_waddr = wptr;
      unique case (lane)
        2'd0: ram_wdata = 32'h0000_0080;
        2'd1: ram_wdata = {16'h0, 8'h80, acc_r[7:0]};
        2'd2: ram_wdata = {8'h0, 8'h80, acc_r[15:0]};
        2'd3: ram_wdata = {8'h80, acc_r};
      endcase
    end else if (cmd.fill_wr) begin
      ram_we = 1'b1;
      if (cmd.fill_len && cmd.word_addr == LEN_LO_WORD) begin
        ram_wdata = bit_cnt_r[31:0];
      end else if (cmd.fill_len && cmd.word_addr == LEN_HI_WORD) begin
        ram_wdata = bit_cnt_r[63:32];
      end
    end
  end

  md5_ram #(
    .WIDTH(32),
    .DEPTH(16)
  ) u_blk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (md5_g(cmd.rd_idx)),
    .rdata (ram_rdata)
  );

  // one MD5 round; ram_rdata holds the word fetched last cycle
  assign q = cmd.rnd_idx[5:4];
  always_comb begin
    unique case (q)
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      2'd3: f = c_r ^ (b_r | ~d_r);
    endcase
  end
  assign sum = a_r + f + MD5_K[cmd.rnd_idx] + ram_rdata;
  assign rot = md5_rotl(sum, MD5_ROT[{q, cmd.rnd_idx[1:0]}]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        cv_r[i] <= MD5_IV[i];
      end
      bit_cnt_r <= '0;
    end else begin
      if (cmd.chain_init) begin
        for (int i = 0; i < 4; i++) begin
          cv_r[i] <= MD5_IV[i];
        end
        bit_cnt_r <= '0;
      end else begin
        if (cmd.chain_add) begin
          cv_r[0] <= cv_r[0] + a_r;
          cv_r[1] <= cv_r[1] + b_r;
          cv_r[2] <= cv_r[2] + c_r;
          cv_r[3] <= cv_r[3] + d_r;
        end
        if (cmd.push_byte) begin
          bit_cnt_r <= bit_cnt_r + 64'd8;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.rnd_load) begin
      a_r <= cv_r[0];
      b_r <= cv_r[1];
      c_r <= cv_r[2];
      d_r <= cv_r[3];
    end else if (cmd.rnd_step) begin
      a_r <= d_r;
      b_r <= b_r + rot;
      c_r <= b_r;
      d_r <= c_r;
    end
  end

endmodule

[rtl/md5_message_digest.sv]
// MD5 message digest. Feed the message one byte per request on the in_ channel
// (in_tuser=1 marks a byte as present, in_tlast=1 ends the message after that
// request's byte; an end request without a byte is allowed, so an empty message
// hashes correctly). The digest comes back as four requests on the out_ channel,
// chaining words A..D in order, out_tuser giving the word index and out_tlast
// flagging word D; digest byte 4i+j is bits 8j+7..8j of word i. The block works
// on one request at a time. Every 64th byte starts a block compression through
// the single-round datapath (one message word fetch plus 64 rounds, one per
// cycle) and a fold into the chaining words, during which in_tready is low. An
// end of message adds the padding words written into the 16-word block buffer
// (up to 16 per padding block), one or two compressions (two when the marker
// byte falls at position 56 or later), then the four digest words, each waiting
// for out_tready. After the last digest word the block re-initializes and is
// ready for the next message. The 64-bit bit count wraps.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // last_word
);
  import md5_pkg::*;

  md5_cmd_t  cmd;
  md5_stat_t stat;

  // sequencer: handshakes, padding walk, round counter, output index
  md5_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: block buffer, bit count, round logic, chaining words
  md5_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
